// File: rtl/core/fdf_pkg.sv
package fdf_pkg;

  localparam int SRC_W = 32;
  localparam int DST_W = 32;
  localparam int NUM_W = 32;
  localparam int TIME_W = 63;
  localparam int OP_W = 2;
  localparam int RM_W = 7;

  localparam int IN_DATA_W = 224;
  localparam int OUT_DATA_W = 104;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd1;
  localparam logic [OP_W-1:0] OP_FLUSH = 2'd2;

  typedef struct packed {
    logic [TIME_W-1:0] expiry;
    logic [NUM_W-1:0]  number;
    logic [DST_W-1:0]  destination;
    logic [SRC_W-1:0]  source;
  } entry_t;

endpackage

// File: rtl/core/fdf_entry_ram.sv
module fdf_entry_ram #(
  parameter int DEPTH = 64,
  parameter int AW = 6
) (
  input  logic            clk,
  input  logic            wr_en,
  input  logic [AW-1:0]   wr_addr,
  input  fdf_pkg::entry_t wr_data,
  input  logic            rd_en,
  input  logic [AW-1:0]   rd_addr,
  output fdf_pkg::entry_t rd_data
);
  import fdf_pkg::*;

  entry_t mem [DEPTH];
  entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read: rd_data holds the entry of the last enabled read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: rtl/core/flood_duplicate_filter_table.sv
// insert writes at acceptance; lookup scans up to a match or expired entry, flush scans all
// one word at a time; a new word is taken only in idle, once the last result is registered
// the scan reads one stored entry per cycle through the single read port of the entry memory
// reset: synchronous active-low rst_n empties the table at once (occupancy and head cleared)
// entry memory contents are not cleared; only live positions are ever read
module flood_duplicate_filter_table #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // in_tdata: src_addr, dst_addr, flood_number, expiry_time, current_time, zero pad
  input  logic [fdf_pkg::IN_DATA_W-1:0]  in_tdata,
  // in_tuser: operation
  input  logic [fdf_pkg::OP_W-1:0]       in_tuser,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // out_tdata: hit, found_dst, found_expiry, removed_count, dropped_oldest
  output logic [fdf_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                           out_tvalid,
  input  logic                           out_tready
);
  import fdf_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(TABLE_DEPTH - 1);
  localparam logic [CW-1:0] FULL_OCC = CW'(TABLE_DEPTH);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  // input word fields
  logic [OP_W-1:0]   in_op;
  logic [SRC_W-1:0]  in_src;
  logic [DST_W-1:0]  in_dst;
  logic [NUM_W-1:0]  in_num;
  logic [TIME_W-1:0] in_exp;
  logic [TIME_W-1:0] in_now;

  assign in_op  = in_tuser;
  assign in_src = in_tdata[31:0];
  assign in_dst = in_tdata[63:32];
  assign in_num = in_tdata[95:64];
  assign in_exp = in_tdata[158:96];
  assign in_now = in_tdata[221:159];

  // control state
  logic [1:0]    state_r, state_nxt;
  logic [CW-1:0] occ_r, occ_nxt;
  logic [AW-1:0] head_r, head_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic          rd_vld_r, rd_vld_nxt;
  logic [CW-1:0] kept_r, kept_nxt;
  logic [CW-1:0] removed_r, removed_nxt;
  logic          out_valid_r, out_valid_nxt;

  // payload
  logic [OP_W-1:0]       op_r, op_nxt;
  logic [SRC_W-1:0]      key_src_r, key_src_nxt;
  logic [NUM_W-1:0]      key_num_r, key_num_nxt;
  logic [TIME_W-1:0]     now_r, now_nxt;
  logic                  res_hit_r, res_hit_nxt;
  logic [DST_W-1:0]      res_dst_r, res_dst_nxt;
  logic [TIME_W-1:0]     res_exp_r, res_exp_nxt;
  logic [RM_W-1:0]       res_rm_r, res_rm_nxt;
  logic                  res_drop_r, res_drop_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  // memory port
  logic          mem_wr_en;
  logic [AW-1:0] mem_wr_addr;
  entry_t        mem_wr_data;
  logic          mem_rd_en;
  entry_t        mem_rd_data;

  logic          accept;
  logic          issue;
  logic          expired;
  logic          match;
  logic [AW-1:0] head_dec;
  logic [AW-1:0] rd_ptr_inc;
  logic [AW-1:0] wr_ptr_inc;
  logic          out_free;

  assign in_tready  = (state_r == ST_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign issue      = (state_r == ST_SCAN) && (idx_r != occ_r);
  assign expired    = (mem_rd_data.expiry < now_r);
  assign match      = (mem_rd_data.source == key_src_r) && (mem_rd_data.number == key_num_r);
  assign head_dec   = (head_r == '0) ? LAST_PTR : head_r - 1'b1;
  assign rd_ptr_inc = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
  assign wr_ptr_inc = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
  assign out_free   = !out_valid_r || out_tready;
  assign mem_rd_en  = issue;

  // logical position 0 (newest) sits at head_r; older entries follow circularly
  always_comb begin
    state_nxt    = state_r;
    occ_nxt      = occ_r;
    head_nxt     = head_r;
    idx_nxt      = idx_r;
    rd_ptr_nxt   = rd_ptr_r;
    wr_ptr_nxt   = wr_ptr_r;
    rd_vld_nxt   = 1'b0;
    kept_nxt     = kept_r;
    removed_nxt  = removed_r;
    op_nxt       = op_r;
    key_src_nxt  = key_src_r;
    key_num_nxt  = key_num_r;
    now_nxt      = now_r;
    res_hit_nxt  = res_hit_r;
    res_dst_nxt  = res_dst_r;
    res_exp_nxt  = res_exp_r;
    res_rm_nxt   = res_rm_r;
    res_drop_nxt = res_drop_r;
    out_data_nxt = out_data_r;
    out_valid_nxt = out_valid_r && !out_tready;
    mem_wr_en    = 1'b0;
    mem_wr_addr  = wr_ptr_r;
    mem_wr_data  = mem_rd_data;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          op_nxt       = in_op;
          key_src_nxt  = in_src;
          key_num_nxt  = in_num;
          now_nxt      = in_now;
          res_hit_nxt  = 1'b0;
          res_dst_nxt  = '0;
          res_exp_nxt  = '0;
          res_rm_nxt   = '0;
          res_drop_nxt = 1'b0;
          case (in_op)
            OP_INSERT: begin
              // new entry goes in front of the newest; a full table loses its oldest
              mem_wr_en   = 1'b1;
              mem_wr_addr = head_dec;
              mem_wr_data = '{expiry: in_exp, number: in_num,
                              destination: in_dst, source: in_src};
              head_nxt    = head_dec;
              if (occ_r == FULL_OCC) begin
                res_drop_nxt = 1'b1;
              end else begin
                occ_nxt = occ_r + 1'b1;
              end
              state_nxt = ST_DONE;
            end
            OP_LOOKUP, OP_FLUSH: begin
              idx_nxt     = '0;
              rd_ptr_nxt  = head_r;
              wr_ptr_nxt  = head_r;
              kept_nxt    = '0;
              removed_nxt = '0;
              state_nxt   = ST_SCAN;
            end
            default: begin
              // unused code: no change, all-zero result
              state_nxt = ST_DONE;
            end
          endcase
        end
      end

      ST_SCAN: begin
        if (issue) begin
          rd_ptr_nxt = rd_ptr_inc;
          idx_nxt    = idx_r + 1'b1;
          rd_vld_nxt = 1'b1;
        end
        if (rd_vld_r) begin
          if (op_r == OP_LOOKUP) begin
            // first expired entry ends the search with a miss
            if (expired) begin
              rd_vld_nxt = 1'b0;
              state_nxt  = ST_DONE;
            end else if (match) begin
              res_hit_nxt = 1'b1;
              res_dst_nxt = mem_rd_data.destination;
              res_exp_nxt = mem_rd_data.expiry;
              rd_vld_nxt  = 1'b0;
              state_nxt   = ST_DONE;
            end
          end else begin
            // compaction: survivors move down to the kept position, order preserved
            if (expired) begin
              removed_nxt = removed_r + 1'b1;
            end else begin
              mem_wr_en   = 1'b1;
              mem_wr_addr = wr_ptr_r;
              mem_wr_data = mem_rd_data;
              wr_ptr_nxt  = wr_ptr_inc;
              kept_nxt    = kept_r + 1'b1;
            end
          end
        end else if (!issue) begin
          // nothing in flight and nothing left to read
          if (op_r == OP_FLUSH) begin
            occ_nxt    = kept_r;
            res_rm_nxt = RM_W'(removed_r);
          end
          state_nxt = ST_DONE;
        end
      end

      ST_DONE: begin
        if (out_free) begin
          out_data_nxt  = {res_drop_r, res_rm_r, res_exp_r, res_dst_r, res_hit_r};
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      occ_r       <= '0;
      head_r      <= '0;
      idx_r       <= '0;
      rd_ptr_r    <= '0;
      wr_ptr_r    <= '0;
      rd_vld_r    <= 1'b0;
      kept_r      <= '0;
      removed_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      occ_r       <= occ_nxt;
      head_r      <= head_nxt;
      idx_r       <= idx_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      wr_ptr_r    <= wr_ptr_nxt;
      rd_vld_r    <= rd_vld_nxt;
      kept_r      <= kept_nxt;
      removed_r   <= removed_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    key_src_r  <= key_src_nxt;
    key_num_r  <= key_num_nxt;
    now_r      <= now_nxt;
    res_hit_r  <= res_hit_nxt;
    res_dst_r  <= res_dst_nxt;
    res_exp_r  <= res_exp_nxt;
    res_rm_r   <= res_rm_nxt;
    res_drop_r <= res_drop_nxt;
    out_data_r <= out_data_nxt;
  end

  fdf_entry_ram #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_entry_ram (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (rd_ptr_r),
    .rd_data (mem_rd_data)
  );

  assign out_tdata  = out_data_r;
  assign out_tvalid = out_valid_r;

`ifndef SYNTHESIS
  // occupancy never exceeds the table depth
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= FULL_OCC)
    else $error("occupancy above table depth");

  // a compaction write never lands on the entry being read
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_wr_en && mem_rd_en) |-> (mem_wr_addr != rd_ptr_r))
    else $error("compaction write overlaps pending read");

  // evaluated entries never outnumber issued reads
  a_scan_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> ({1'b0, kept_r} + {1'b0, removed_r} <= {1'b0, idx_r}))
    else $error("scan bookkeeping ahead of reads");

  // a flush never grows the table
  a_flush_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN && op_r == OP_FLUSH) |=> (occ_r <= $past(occ_r)))
    else $error("flush increased occupancy");
`endif

endmodule
